/* rtl/core/ptm_pkg.sv */
// Types, constants and the control store shared by the page table mapper.
package ptm_pkg;

  localparam int PTM_POOL_PAGES    = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int EIDX_W            = 15;
  localparam int VA_W              = 48;
  localparam int PA_W              = 52;
  localparam int PTE_W             = 64;
  localparam int PAGE_SHIFT        = 12;
  localparam int FRAME_W           = PA_W - PAGE_SHIFT;
  localparam int NFP_W             = 7;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_W             = PA_W;

  localparam logic [PTE_W-1:0] ENTRY_P  = 64'h1;
  localparam logic [PTE_W-1:0] ENTRY_RW = 64'h2;

  localparam logic [1:0] LVL_ROOT = 2'd3;

  localparam logic [1:0] SZ_4K  = 2'd0;
  localparam logic [1:0] SZ_2M  = 2'd1;
  localparam logic [1:0] SZ_1G  = 2'd2;
  localparam logic [1:0] SZ_BAD = 2'd3;

  localparam logic OP_MAP  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PAGES = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SIZE   = 2'd1,
    ST_POOL_EMPTY = 2'd2,
    ST_MAPPED     = 2'd3
  } ptm_status_t;

  typedef struct packed {
    logic              op;
    logic [VA_W-1:0]   virt_addr;
    logic [PA_W-1:0]   phys_addr;
    logic [PTE_W-1:0]  attr_flags;
    logic              make_absent;
    logic [1:0]        size_code;
    logic [EIDX_W-1:0] entry_index;
  } ptm_req_t;

  typedef struct packed {
    ptm_status_t      status;
    logic [NFP_W-1:0] tables_used;
    logic [PTE_W-1:0] entry_data;
  } ptm_rsp_t;

  // Program steps of the control store.
  typedef enum logic [4:0] {
    S_RST       = 5'd0,
    S_IDLE      = 5'd1,
    S_DISPATCH  = 5'd2,
    S_SIZE      = 5'd3,
    S_BAD       = 5'd4,
    S_WALK      = 5'd5,
    S_TAB_RD    = 5'd6,
    S_TAB_CHK   = 5'd7,
    S_POOL      = 5'd8,
    S_ALLOC     = 5'd9,
    S_CLR       = 5'd10,
    S_LINK_WR   = 5'd11,
    S_LINK      = 5'd12,
    S_FAIL_MAP  = 5'd13,
    S_LEAF_RD   = 5'd14,
    S_LEAF_CHK  = 5'd15,
    S_LEAF_WR   = 5'd16,
    S_FAIL_POOL = 5'd17,
    S_READ      = 5'd18,
    S_READ_CAP  = 5'd19,
    S_DONE      = 5'd20,
    S_RET       = 5'd21
  } ptm_step_t;

  typedef enum logic [3:0] {
    C_NONE       = 4'd0,
    C_ALWAYS     = 4'd1,
    C_NO_ACCEPT  = 4'd2,
    C_OP_READ    = 4'd3,
    C_SIZE_OK    = 4'd4,
    C_AT_LEAF    = 4'd5,
    C_PRESENT    = 4'd6,
    C_POOL_FULL  = 4'd7,
    C_IN_POOL    = 4'd8,
    C_CNT_MORE   = 4'd9,
    C_SWEEP_MORE = 4'd10,
    C_OUT_BUSY   = 4'd11
  } ptm_cond_t;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_RD   = 2'd1,
    MEM_WR   = 2'd2
  } ptm_mem_t;

  typedef enum logic [1:0] {
    A_WALK  = 2'd0,
    A_CLEAR = 2'd1,
    A_EIDX  = 2'd2
  } ptm_asel_t;

  typedef enum logic [1:0] {
    W_ZERO = 2'd0,
    W_ENT  = 2'd1,
    W_LEAF = 2'd2
  } ptm_wsel_t;

  typedef enum logic [1:0] {
    D_KEEP = 2'd0,
    D_READ = 2'd1,
    D_LEAF = 2'd2
  } ptm_dsel_t;

  typedef struct packed {
    ptm_cond_t   cond;
    ptm_step_t   target;
    ptm_mem_t    mem;
    ptm_asel_t   asel;
    ptm_wsel_t   wsel;
    ptm_dsel_t   dsel;
    logic        in_ready;
    logic        cnt_inc;
    logic        page_step;
    logic        alloc;
    logic        ent_ld;
    logic        walk_step;
    logic        st_ld;
    ptm_status_t st_val;
    logic        out_ld;
  } ptm_cw_t;

  typedef struct packed {
    logic no_accept;
    logic op_read;
    logic size_ok;
    logic at_leaf;
    logic present;
    logic pool_full;
    logic in_pool;
    logic cnt_more;
    logic sweep_more;
    logic out_busy;
  } ptm_flags_t;

  // Control store: one word per step; jump to target when cond holds, else step on.
  function automatic ptm_cw_t ptm_ucode(input ptm_step_t step);
    ptm_cw_t cw;
    cw = '0;
    unique case (step)
      S_RST: begin
        cw.mem       = MEM_WR;
        cw.asel      = A_CLEAR;
        cw.wsel      = W_ZERO;
        cw.cnt_inc   = 1'b1;
        cw.page_step = 1'b1;
        cw.cond      = C_SWEEP_MORE;
        cw.target    = S_RST;
      end
      S_IDLE: begin
        cw.in_ready = 1'b1;
        cw.cond     = C_NO_ACCEPT;
        cw.target   = S_IDLE;
      end
      S_DISPATCH: begin
        cw.cond   = C_OP_READ;
        cw.target = S_READ;
      end
      S_SIZE: begin
        cw.cond   = C_SIZE_OK;
        cw.target = S_WALK;
      end
      S_BAD: begin
        cw.st_ld  = 1'b1;
        cw.st_val = ST_BAD_SIZE;
        cw.cond   = C_ALWAYS;
        cw.target = S_DONE;
      end
      S_WALK: begin
        cw.cond   = C_AT_LEAF;
        cw.target = S_LEAF_RD;
      end
      S_TAB_RD: begin
        cw.mem  = MEM_RD;
        cw.asel = A_WALK;
      end
      S_TAB_CHK: begin
        cw.ent_ld = 1'b1;
        cw.cond   = C_PRESENT;
        cw.target = S_LINK;
      end
      S_POOL: begin
        cw.cond   = C_POOL_FULL;
        cw.target = S_FAIL_POOL;
      end
      S_ALLOC: begin
        cw.alloc = 1'b1;
      end
      S_CLR: begin
        cw.mem     = MEM_WR;
        cw.asel    = A_CLEAR;
        cw.wsel    = W_ZERO;
        cw.cnt_inc = 1'b1;
        cw.cond    = C_CNT_MORE;
        cw.target  = S_CLR;
      end
      S_LINK_WR: begin
        cw.mem  = MEM_WR;
        cw.asel = A_WALK;
        cw.wsel = W_ENT;
      end
      S_LINK: begin
        cw.walk_step = 1'b1;
        cw.cond      = C_IN_POOL;
        cw.target    = S_WALK;
      end
      S_FAIL_MAP: begin
        cw.st_ld  = 1'b1;
        cw.st_val = ST_MAPPED;
        cw.cond   = C_ALWAYS;
        cw.target = S_DONE;
      end
      S_LEAF_RD: begin
        cw.mem  = MEM_RD;
        cw.asel = A_WALK;
      end
      S_LEAF_CHK: begin
        cw.cond   = C_PRESENT;
        cw.target = S_FAIL_MAP;
      end
      S_LEAF_WR: begin
        cw.mem    = MEM_WR;
        cw.asel   = A_WALK;
        cw.wsel   = W_LEAF;
        cw.dsel   = D_LEAF;
        cw.cond   = C_ALWAYS;
        cw.target = S_DONE;
      end
      S_FAIL_POOL: begin
        cw.st_ld  = 1'b1;
        cw.st_val = ST_POOL_EMPTY;
        cw.cond   = C_ALWAYS;
        cw.target = S_DONE;
      end
      S_READ: begin
        cw.mem  = MEM_RD;
        cw.asel = A_EIDX;
      end
      S_READ_CAP: begin
        cw.dsel = D_READ;
      end
      S_DONE: begin
        cw.out_ld = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.target = S_DONE;
      end
      S_RET: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_IDLE;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

/* rtl/core/ptm_stream_if.sv */
// Valid/ready stream channel carrying one payload word.
interface ptm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/ptm_useq.sv */
// Step counter and condition decode driving the control store.
module ptm_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  ptm_pkg::ptm_flags_t flags,
  output ptm_pkg::ptm_cw_t    cw
);
  import ptm_pkg::*;

  ptm_step_t pc_r;
  ptm_step_t pc_nxt;
  logic      take;

  always_comb cw = ptm_ucode(pc_r);

  always_comb begin
    unique case (cw.cond)
      C_NONE:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ACCEPT:  take = flags.no_accept;
      C_OP_READ:    take = flags.op_read;
      C_SIZE_OK:    take = flags.size_ok;
      C_AT_LEAF:    take = flags.at_leaf;
      C_PRESENT:    take = flags.present;
      C_POOL_FULL:  take = flags.pool_full;
      C_IN_POOL:    take = flags.in_pool;
      C_CNT_MORE:   take = flags.cnt_more;
      C_SWEEP_MORE: take = flags.sweep_more;
      C_OUT_BUSY:   take = flags.out_busy;
      default:      take = 1'b0;
    endcase
  end

  always_comb pc_nxt = take ? cw.target : ptm_step_t'(pc_r + 5'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_RST;
    end else begin
      pc_r <= pc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.in_ready && !flags.no_accept) |=> pc_r == S_DISPATCH)
    else $error("accepted word did not move to dispatch");

  a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_RST && !flags.sweep_more) |=> pc_r == S_IDLE)
    else $error("clearing pass did not end in idle");

  a_no_reenter: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != S_RST |=> pc_r != S_RST)
    else $error("clearing pass re-entered outside reset");
`endif

endmodule

/* rtl/core/ptm_dpath.sv */
// Table store, walk registers, allocator and result register.
module ptm_dpath #(
  parameter int POOL_PAGES = ptm_pkg::PTM_POOL_PAGES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptm_pkg::ptm_cw_t          cw,
  output ptm_pkg::ptm_flags_t       flags,
  input  logic                      in_accept,
  input  ptm_pkg::ptm_req_t         in_word,
  input  logic [ptm_pkg::PA_W-1:0]  pool_base,
  input  logic [ptm_pkg::NFP_W-1:0] pool_pages,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ptm_pkg::ptm_rsp_t         out_word
);
  import ptm_pkg::*;

  localparam int PAGE_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int ADDR_W = PAGE_W + IDX_W;
  localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_TABLE;

  logic [PTE_W-1:0]  mem [DEPTH];
  logic [PTE_W-1:0]  rd_r;

  logic              op_r;
  logic [VA_W-1:0]   va_r;
  logic [PA_W-1:0]   pa_r;
  logic [PTE_W-1:0]  flags_r;
  logic              absent_r;
  logic [1:0]        size_r;
  logic [EIDX_W-1:0] eidx_r;
  logic [1:0]        lvl_r;
  logic [PAGE_W-1:0] cur_r;
  logic [PTE_W-1:0]  ent_r;
  ptm_status_t       status_r;
  logic [PTE_W-1:0]  data_r;

  logic [NFP_W-1:0]  nfp_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [PAGE_W-1:0] clr_page_r;
  logic              out_valid_r;
  ptm_rsp_t          out_r;

  logic [VA_W-1:0]    va_al;
  logic [PA_W-1:0]    pa_al;
  logic [IDX_W-1:0]   walk_idx;
  logic [ADDR_W-1:0]  addr;
  logic [PTE_W-1:0]   wdata;
  logic [FRAME_W-1:0] off;
  logic [FRAME_W-1:0] new_frame;
  logic [PTE_W-1:0]   link_ent;
  logic [PTE_W-1:0]   leaf_ent;
  logic               rd_in_pool;
  logic               cnt_last;
  logic               page_last;
  logic               out_busy;
  logic               out_take;

  // Align both addresses down to the requested page size; a bad size code passes them unchanged.
  always_comb begin
    case (in_word.size_code)
      SZ_4K: begin
        va_al = {in_word.virt_addr[VA_W-1:12], 12'd0};
        pa_al = {in_word.phys_addr[PA_W-1:12], 12'd0};
      end
      SZ_2M: begin
        va_al = {in_word.virt_addr[VA_W-1:21], 21'd0};
        pa_al = {in_word.phys_addr[PA_W-1:21], 21'd0};
      end
      SZ_1G: begin
        va_al = {in_word.virt_addr[VA_W-1:30], 30'd0};
        pa_al = {in_word.phys_addr[PA_W-1:30], 30'd0};
      end
      default: begin
        va_al = in_word.virt_addr;
        pa_al = in_word.phys_addr;
      end
    endcase
  end

  always_comb begin
    case (lvl_r)
      2'd0:    walk_idx = va_r[20:12];
      2'd1:    walk_idx = va_r[29:21];
      2'd2:    walk_idx = va_r[38:30];
      default: walk_idx = va_r[47:39];
    endcase
  end

  always_comb begin
    unique case (cw.asel)
      A_WALK:  addr = {cur_r, walk_idx};
      A_CLEAR: addr = {clr_page_r, cnt_r};
      A_EIDX:  addr = ADDR_W'(eidx_r);
      default: addr = {cur_r, walk_idx};
    endcase
  end

  always_comb begin
    unique case (cw.wsel)
      W_ZERO:  wdata = '0;
      W_ENT:   wdata = ent_r;
      W_LEAF:  wdata = leaf_ent;
      default: wdata = '0;
    endcase
  end

  // Page offset of a linked entry from the pool base, modulo 2^40.
  assign off       = ent_r[PA_W-1:PAGE_SHIFT] - pool_base[PA_W-1:PAGE_SHIFT];
  assign new_frame = pool_base[PA_W-1:PAGE_SHIFT] + FRAME_W'(nfp_r);
  assign link_ent  = {{(PTE_W-PA_W){1'b0}}, new_frame, {PAGE_SHIFT{1'b0}}}
                     | ENTRY_P | ENTRY_RW;
  assign leaf_ent  = {{(PTE_W-PA_W){1'b0}}, pa_r} | flags_r
                     | (absent_r ? '0 : ENTRY_P);

  assign rd_in_pool = 32'(eidx_r[EIDX_W-1:IDX_W]) < POOL_PAGES;
  assign cnt_last   = cnt_r == '1;
  assign page_last  = clr_page_r == PAGE_W'(POOL_PAGES - 1);
  assign out_busy   = out_valid_r & ~out_ready;
  assign out_take   = cw.out_ld & ~out_busy;

  always_comb begin
    flags.no_accept  = ~in_accept;
    flags.op_read    = op_r == OP_READ;
    flags.size_ok    = size_r != SZ_BAD;
    flags.at_leaf    = lvl_r == size_r;
    flags.present    = (rd_r & ENTRY_P) != '0;
    flags.pool_full  = (nfp_r >= pool_pages) || (32'(nfp_r) >= POOL_PAGES);
    flags.in_pool    = off < FRAME_W'(POOL_PAGES);
    flags.cnt_more   = ~cnt_last;
    flags.sweep_more = ~(cnt_last & page_last);
    flags.out_busy   = out_busy;
  end

  always_ff @(posedge clk) begin
    if (cw.mem == MEM_WR) begin
      mem[addr] <= wdata;
    end
    if (cw.mem == MEM_RD) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_word.op;
      va_r     <= va_al;
      pa_r     <= pa_al;
      flags_r  <= in_word.attr_flags;
      absent_r <= in_word.make_absent;
      size_r   <= in_word.size_code;
      eidx_r   <= in_word.entry_index;
      lvl_r    <= LVL_ROOT;
      cur_r    <= '0;
      status_r <= ST_OK;
      data_r   <= '0;
    end else begin
      if (cw.ent_ld) begin
        ent_r <= rd_r;
      end
      if (cw.alloc) begin
        ent_r <= link_ent;
      end
      // descend: the linked page becomes the current table
      if (cw.walk_step) begin
        cur_r <= PAGE_W'(off);
        lvl_r <= lvl_r - 2'd1;
      end
      if (cw.st_ld) begin
        status_r <= cw.st_val;
      end
      case (cw.dsel)
        D_READ:  data_r <= rd_in_pool ? rd_r : '0;
        D_LEAF:  data_r <= leaf_ent;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfp_r       <= NFP_W'(1);
      cnt_r       <= '0;
      clr_page_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cw.alloc) begin
        nfp_r      <= nfp_r + NFP_W'(1);
        clr_page_r <= PAGE_W'(nfp_r);
        cnt_r      <= '0;
      end
      if (cw.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      // advance to the next page once the last entry of this one is cleared
      if (cw.page_step && cnt_last) begin
        clr_page_r <= clr_page_r + PAGE_W'(1);
      end
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_r.status      <= status_r;
      out_r.tables_used <= nfp_r;
      out_r.entry_data  <= data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTHESIS
  a_nfp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cw.alloc |=> $stable(nfp_r))
    else $error("free page count moved without an allocation");

  a_leaf_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.mem == MEM_WR && cw.wsel == W_LEAF) |-> (rd_r & ENTRY_P) == '0)
    else $error("leaf written over a present entry");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cw.out_ld))
    else $error("result raised without a load step");
`endif

endmodule

/* rtl/core/page_table_map_insert.sv */
// Four-level x86-64 page table builder over a pool of table pages, held in
// a single-port store of POOL_PAGES x 512 entries with registered reads.
// After reset a clearing pass writes every entry to zero, one per cycle,
// during which no word is taken (configuration writes are). A map walks the
// levels above the leaf, reading and checking one entry per level, then
// reads and writes the leaf of a 4 KiB, 2 MiB or 1 GiB page. Each missing
// table adds an allocation and a sweep that clears the new page through the
// single store port. A finished result sits in the output register, so the
// next word is taken while it waits.
module page_table_map_insert #(
  parameter int POOL_PAGES = ptm_pkg::PTM_POOL_PAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ptm_stream_if.sink                    in_req,
  ptm_stream_if.source                  out_rsp,
  input  logic                          cfg_we,
  input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptm_pkg::CFG_W-1:0]     cfg_wdata
);
  import ptm_pkg::*;

  logic [PA_W-1:0]  pool_base_r;
  logic [NFP_W-1:0] pool_pages_r;
  ptm_cw_t          cw;
  ptm_flags_t       flags;
  logic             in_accept;
  ptm_rsp_t         rsp_word;
  logic             rsp_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      pool_pages_r <= NFP_W'(PTM_POOL_PAGES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:  pool_base_r  <= cfg_wdata;
        REG_POOL_PAGES: pool_pages_r <= cfg_wdata[NFP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_req.ready = cw.in_ready;
  assign in_accept    = in_req.valid & cw.in_ready;

  ptm_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  ptm_dpath #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .flags      (flags),
    .in_accept  (in_accept),
    .in_word    (in_req.payload),
    .pool_base  (pool_base_r),
    .pool_pages (pool_pages_r),
    .out_valid  (rsp_valid),
    .out_ready  (out_rsp.ready),
    .out_word   (rsp_word)
  );

  assign out_rsp.valid   = rsp_valid;
  assign out_rsp.payload = rsp_word;

endmodule
